// ===== src/mhcs_pkg.sv =====
// ---------------------------------------------------------------------------
// Cooking sequencer package
// Payload types, codes, recipe tables and the controller/datapath interface.
// ---------------------------------------------------------------------------
package mhcs_pkg;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] key_id;
      logic       key_pressed;
      logic [7:0] head;
      logic [2:0] command;
      logic [7:0] argument;
      logic [7:0] temperature;
   } mhcs_req_type;

   typedef struct packed {
      logic        result_kind;
      logic [1:0]  out_head;
      logic        power_on;
      logic [10:0] power_watts;
      logic [3:0]  power_level_out;
      logic        hold_mode;
      logic [7:0]  target_temp_out;
      logic [1:0]  display_code;
      logic        last_result;
   } mhcs_rsp_type;

   localparam logic [1:0] FUNC_KEY  = 2'd0;
   localparam logic [1:0] FUNC_TEMP = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;
   localparam logic [1:0] FUNC_CMD  = 2'd3;

   localparam logic [7:0] KEY_NEXT     = 8'h01;
   localparam logic [7:0] KEY_STOP     = 8'h02;
   localparam logic [7:0] KEY_WARM     = 8'h04;
   localparam logic [7:0] KEY_LEVEL_LO = 8'h10;
   localparam logic [7:0] KEY_LEVEL_HI = 8'h19;

   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_START  = 3'd1;
   localparam logic [2:0] CMD_STOP   = 3'd2;
   localparam logic [2:0] CMD_PAUSE  = 3'd3;
   localparam logic [2:0] CMD_RESUME = 3'd4;
   localparam logic [2:0] CMD_LEVEL  = 3'd5;

   localparam logic [1:0] RUN_OFF    = 2'd0;
   localparam logic [1:0] RUN_ACTIVE = 2'd1;
   localparam logic [1:0] RUN_PAUSED = 2'd2;
   localparam logic [1:0] RUN_DONE   = 2'd3;

   localparam logic [1:0] DISP_STOPPED  = 2'd0;
   localparam logic [1:0] DISP_STARTED  = 2'd1;
   localparam logic [1:0] DISP_COMPLETE = 2'd2;

   localparam logic KIND_POWER   = 1'b0;
   localparam logic KIND_DISPLAY = 1'b1;

   localparam logic [1:0] STEP_NONE  = 2'd0;
   localparam logic [1:0] STEP_FIXED = 2'd1;
   localparam logic [1:0] STEP_BOIL  = 2'd2;
   localparam logic [1:0] STEP_HOLD  = 2'd3;

   localparam logic [7:0] CSR_BOIL_MIN_TEMP    = 8'd0;
   localparam logic [7:0] CSR_BOIL_MIN_SAMPLES = 8'd1;
   localparam logic [7:0] CSR_BOIL_TOLERANCE   = 8'd2;
   localparam logic [7:0] CSR_HOLD_BAND        = 8'd3;

   localparam int         TABLE_MENUS = 4;
   localparam logic [3:0] MAX_RESULTS = 4'd8;
   localparam logic [7:0] MAX_LEVEL   = 8'd10;
   localparam logic [7:0] WARM_MENU   = 8'd1;
   localparam logic [7:0] RESET_TEMP  = 8'd25;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  level;
      logic [15:0] seconds;
      logic [7:0]  target;
   } mhcs_step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_TICK_CHECK,
      ST_WAIT_DIV,
      ST_EMIT,
      ST_FLUSH
   } mhcs_state_type;

   typedef struct packed {
      logic latch;
      logic next_head;
      logic eval;
      logic apply;
      logic push;
      logic drop;
      logic flush;
   } mhcs_cmd_type;

   typedef struct packed {
      logic tick_op;
      logic tick_active;
      logic last_head;
      logic div_busy;
      logic slot_have;
      logic res_full;
      logic pend_valid;
      logic out_free;
   } mhcs_status_type;

   function automatic mhcs_step_type step_of(input logic [1:0] menu, input logic pos);
      mhcs_step_type s;
      s = '0;
      unique case ({menu, pos})
         3'b010:  s = '{kind: STEP_HOLD,  level: 4'd3,  seconds: 16'd0,    target: 8'd65};
         3'b100:  s = '{kind: STEP_FIXED, level: 4'd5,  seconds: 16'd0,    target: 8'd0};
         3'b110:  s = '{kind: STEP_BOIL,  level: 4'd10, seconds: 16'd0,    target: 8'd0};
         3'b111:  s = '{kind: STEP_FIXED, level: 4'd2,  seconds: 16'd1800, target: 8'd0};
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [1:0] menu_len(input logic [1:0] menu);
      logic [1:0] n;
      unique case (menu)
         2'd1:    n = 2'd1;
         2'd2:    n = 2'd1;
         2'd3:    n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [10:0] watts_of(input logic [3:0] lv);
      logic [10:0] w;
      unique case (lv)
         4'd1:    w = 11'd200;
         4'd2:    w = 11'd300;
         4'd3:    w = 11'd400;
         4'd4:    w = 11'd500;
         4'd5:    w = 11'd1000;
         4'd6:    w = 11'd1100;
         4'd7:    w = 11'd1200;
         4'd8:    w = 11'd1300;
         4'd9:    w = 11'd1500;
         4'd10:   w = 11'd2000;
         default: w = 11'd0;
      endcase
      return w;
   endfunction

   function automatic mhcs_rsp_type power_res(input logic [1:0] h, input logic on,
                                              input logic [10:0] w, input logic [3:0] lv,
                                              input logic md, input logic [7:0] tgt);
      mhcs_rsp_type r;
      r = '0;
      r.result_kind     = KIND_POWER;
      r.out_head        = h;
      r.power_on        = on;
      r.power_watts     = w;
      r.power_level_out = lv;
      r.hold_mode       = md;
      r.target_temp_out = tgt;
      return r;
   endfunction

   function automatic mhcs_rsp_type disp_res(input logic [1:0] h, input logic [1:0] code);
      mhcs_rsp_type r;
      r = '0;
      r.result_kind  = KIND_DISPLAY;
      r.out_head     = h;
      r.display_code = code;
      return r;
   endfunction

endpackage

// ===== src/mhcs_div.sv =====
// ---------------------------------------------------------------------------
// Boil average divider
// Restoring 16 by 8 bit divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mhcs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [7:0]  divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] q_ff, q_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  dvs_ff, dvs_in;
   logic [8:0]  trial;

   assign trial = {rem_ff, q_ff[15]};

   always_comb begin
      cnt_in = cnt_ff;
      q_in   = q_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = 5'd16;
         q_in   = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != 5'd0) begin
         cnt_in = cnt_ff - 5'd1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 8'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = trial[7:0];
            q_in   = {q_ff[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != 5'd0);
   assign quotient = q_ff;
endmodule

// ===== src/mhcs_datapath.sv =====
// ---------------------------------------------------------------------------
// Cooking sequencer datapath
// Per-head state, configuration, step evaluation and result staging.
// ---------------------------------------------------------------------------
module mhcs_datapath #(
   parameter int HEADS = 4,
   parameter int MENUS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mhcs_pkg::mhcs_req_type  req_payload,
   input  logic                    csr_valid,
   input  logic [7:0]              csr_index,
   input  logic [7:0]              csr_data,
   input  mhcs_pkg::mhcs_cmd_type  cmd,
   output mhcs_pkg::mhcs_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mhcs_pkg::mhcs_rsp_type  rsp_payload
);
   import mhcs_pkg::*;

   localparam int         HW      = (HEADS > 1) ? $clog2(HEADS) : 1;
   localparam logic [7:0] HEADS_B = 8'(HEADS);
   localparam logic [7:0] MENUS_B = 8'(MENUS);

   // Configuration registers.
   logic [7:0] min_temp_ff, min_samp_ff, tol_ff, band_ff;

   // Latched item.
   logic [1:0]    op_ff;
   logic [2:0]    ccmd_ff;
   logic [7:0]    carg_ff;
   logic          cnext_ff;
   logic [7:0]    temp_ff;
   logic [HW-1:0] hd_ff, hd_in;
   logic          hd_ok_ff;

   // Per-head state.
   logic [1:0]  run_ff   [HEADS];
   logic [1:0]  menu_ff  [HEADS];
   logic [1:0]  pos_ff   [HEADS];
   logic [15:0] cd_ff    [HEADS];
   logic [7:0]  htemp_ff [HEADS];
   logic [3:0]  lvl_ff   [HEADS];
   logic [7:0]  bcnt_ff  [HEADS];
   logic [15:0] bsum_ff  [HEADS];
   logic [HW-1:0] sel_ff;

   logic [7:0]  wcnt_ff;
   logic [15:0] wsum_ff;

   // Result staging.
   mhcs_rsp_type slot0_ff, slot1_ff, pend_ff, out_ff;
   mhcs_rsp_type out_nx;
   logic [1:0]   slotn_ff, sloti_ff;
   logic [3:0]   rescnt_ff;
   logic         pend_v_ff, out_v_ff;

   // Current head view.
   logic [1:0]  c_run, c_menu, c_pos;
   logic [15:0] c_cd, c_bsum;
   logic [7:0]  c_temp, c_bcnt;
   logic [3:0]  c_lvl;
   logic [1:0]  h2;
   mhcs_step_type s, s_next, s_start;

   logic [15:0] cd_dec;
   logic [3:0]  lv_user;
   logic        below;
   logic [7:0]  cnt_inc;
   logic [16:0] sum_wide;
   logic [15:0] sum_sat;
   logic        need_div;
   logic        div_busy;
   logic [15:0] avg;
   logic [15:0] t16, diff;
   logic        boil;
   logic [8:0]  band_sum;
   logic [10:0] hold_w;
   logic        step_next;
   logic [1:0]  pos_inc;
   logic        step_done;
   logic        arg_ok;
   logic        out_xfer;
   mhcs_rsp_type step_res;

   logic [1:0]  n_run, n_menu, n_pos;
   logic [15:0] n_cd, n_bsum;
   logic [7:0]  n_temp, n_bcnt;
   logic [3:0]  n_lvl;
   logic [HW-1:0] n_sel;
   mhcs_rsp_type n_slot0, n_slot1;
   logic [1:0]  n_slotn;

   assign c_run  = run_ff[hd_ff];
   assign c_menu = menu_ff[hd_ff];
   assign c_pos  = pos_ff[hd_ff];
   assign c_cd   = cd_ff[hd_ff];
   assign c_temp = htemp_ff[hd_ff];
   assign c_lvl  = lvl_ff[hd_ff];
   assign c_bcnt = bcnt_ff[hd_ff];
   assign c_bsum = bsum_ff[hd_ff];
   assign h2     = 2'(hd_ff);

   assign s       = step_of(c_menu, c_pos[0]);
   assign pos_inc = c_pos + 2'd1;
   assign s_next  = step_of(c_menu, pos_inc[0]);
   assign s_start = step_of(carg_ff[1:0], 1'b0);

   assign cd_dec   = (c_cd == 16'd0) ? 16'd0 : c_cd - 16'd1;
   assign lv_user  = (c_lvl != 4'd0) ? c_lvl : s.level;
   assign below    = (c_temp < min_temp_ff);
   assign cnt_inc  = (c_bcnt == 8'hFF) ? 8'hFF : c_bcnt + 8'd1;
   assign sum_wide = {1'b0, c_bsum} + {9'b0, c_temp};
   assign sum_sat  = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
   assign need_div = (s.kind == STEP_BOIL) && !below && (cnt_inc >= min_samp_ff);

   mhcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.eval && need_div),
      .dividend (sum_sat),
      .divisor  (cnt_inc),
      .busy     (div_busy),
      .quotient (avg)
   );

   // The sampled count and sum were captured when the step was evaluated.
   assign t16  = {8'b0, c_temp};
   assign diff = (t16 >= avg) ? t16 - avg : avg - t16;
   assign boil = !below && (wcnt_ff >= min_samp_ff) && (diff < {8'b0, tol_ff});

   assign band_sum = {1'b0, c_temp} + {1'b0, band_ff};

   always_comb begin
      if (band_sum < {1'b0, s.target}) begin
         hold_w = watts_of(lv_user);
      end else if (c_temp > s.target) begin
         hold_w = 11'd0;
      end else if (lv_user > 4'd2) begin
         hold_w = watts_of(lv_user - 4'd2);
      end else begin
         hold_w = watts_of(4'd1);
      end
   end

   always_comb begin
      unique case (s.kind)
         STEP_FIXED: begin
            step_res  = power_res(h2, 1'b1, watts_of(lv_user), lv_user, 1'b0, 8'd0);
            step_next = (cd_dec == 16'd0) && (s.seconds != 16'd0);
         end
         STEP_BOIL: begin
            step_res  = power_res(h2, 1'b1, watts_of(s.level), s.level, 1'b0, 8'd0);
            step_next = boil;
         end
         STEP_HOLD: begin
            step_res  = power_res(h2, hold_w != 11'd0, hold_w, lv_user, 1'b1, s.target);
            step_next = (cd_dec == 16'd0) && (s.seconds != 16'd0);
         end
         default: begin
            step_res  = '0;
            step_next = 1'b1;
         end
      endcase
   end

   assign step_done = (pos_inc >= menu_len(c_menu));
   assign arg_ok    = (carg_ff != 8'd0) && (carg_ff < MENUS_B) &&
                      (carg_ff < 8'(TABLE_MENUS)) && (menu_len(carg_ff[1:0]) != 2'd0);

   always_comb begin
      n_run   = c_run;
      n_menu  = c_menu;
      n_pos   = c_pos;
      n_cd    = c_cd;
      n_temp  = c_temp;
      n_lvl   = c_lvl;
      n_bcnt  = c_bcnt;
      n_bsum  = c_bsum;
      n_sel   = sel_ff;
      n_slot0 = '0;
      n_slot1 = '0;
      n_slotn = 2'd0;
      if (op_ff == FUNC_TICK) begin
         n_cd = cd_dec;
         if (s.kind == STEP_BOIL) begin
            if (below || boil) begin
               n_bcnt = '0;
               n_bsum = '0;
            end else begin
               n_bcnt = wcnt_ff;
               n_bsum = wsum_ff;
            end
         end
         if (step_next && step_done) begin
            // A finished recipe replaces the step power with power off.
            n_pos   = pos_inc;
            n_run   = RUN_DONE;
            n_slot0 = power_res(h2, 1'b0, 11'd0, 4'd0, 1'b0, 8'd0);
            n_slot1 = disp_res(h2, DISP_COMPLETE);
            n_slotn = 2'd2;
         end else begin
            if (step_next) begin
               n_pos  = pos_inc;
               n_cd   = s_next.seconds;
               n_bcnt = '0;
               n_bsum = '0;
            end
            n_slot0 = step_res;
            n_slotn = (s.kind != STEP_NONE) ? 2'd1 : 2'd0;
         end
      end else if (op_ff == FUNC_TEMP) begin
         if (hd_ok_ff) begin
            n_temp = temp_ff;
         end
      end else if (cnext_ff) begin
         n_sel = (sel_ff == HW'(HEADS - 1)) ? '0 : sel_ff + 1'b1;
      end else if (hd_ok_ff) begin
         unique case (ccmd_ff)
            CMD_START: begin
               if (arg_ok) begin
                  n_menu  = carg_ff[1:0];
                  n_pos   = 2'd0;
                  n_cd    = s_start.seconds;
                  n_bcnt  = '0;
                  n_bsum  = '0;
                  n_run   = RUN_ACTIVE;
                  n_slot0 = disp_res(h2, DISP_STARTED);
                  n_slotn = 2'd1;
               end
            end
            CMD_STOP: begin
               n_run   = RUN_OFF;
               n_menu  = 2'd0;
               n_slot0 = power_res(h2, 1'b0, 11'd0, 4'd0, 1'b0, 8'd0);
               n_slot1 = disp_res(h2, DISP_STOPPED);
               n_slotn = 2'd2;
            end
            CMD_PAUSE: begin
               if (c_run == RUN_ACTIVE) begin
                  n_run   = RUN_PAUSED;
                  n_slot0 = power_res(h2, 1'b0, 11'd0, 4'd0, 1'b0, 8'd0);
                  n_slotn = 2'd1;
               end
            end
            CMD_RESUME: begin
               if (c_run == RUN_PAUSED) begin
                  n_run = RUN_ACTIVE;
               end
            end
            CMD_LEVEL: begin
               if (carg_ff <= MAX_LEVEL) begin
                  n_lvl = carg_ff[3:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Item decode: keys act on the selected head, reports and commands on their own.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_payload.func;
         temp_ff  <= req_payload.temperature;
         ccmd_ff  <= CMD_NONE;
         carg_ff  <= req_payload.argument;
         cnext_ff <= 1'b0;
         unique case (req_payload.func)
            FUNC_KEY: begin
               hd_ok_ff <= 1'b1;
               if (req_payload.key_pressed) begin
                  if (req_payload.key_id == KEY_NEXT) begin
                     cnext_ff <= 1'b1;
                  end else if (req_payload.key_id == KEY_STOP) begin
                     ccmd_ff <= CMD_STOP;
                  end else if (req_payload.key_id == KEY_WARM) begin
                     ccmd_ff <= CMD_START;
                     carg_ff <= WARM_MENU;
                  end else if (req_payload.key_id >= KEY_LEVEL_LO &&
                               req_payload.key_id <= KEY_LEVEL_HI) begin
                     ccmd_ff <= CMD_LEVEL;
                     carg_ff <= req_payload.key_id - KEY_LEVEL_LO;
                  end
               end
            end
            FUNC_CMD: begin
               hd_ok_ff <= (req_payload.head < HEADS_B);
               ccmd_ff  <= req_payload.command;
            end
            default: begin
               hd_ok_ff <= (req_payload.head < HEADS_B);
            end
         endcase
      end
      if (cmd.eval) begin
         wcnt_ff <= cnt_inc;
         wsum_ff <= sum_sat;
      end
   end

   always_comb begin
      hd_in = hd_ff;
      if (cmd.latch) begin
         unique case (req_payload.func)
            FUNC_KEY:  hd_in = sel_ff;
            FUNC_TICK: hd_in = '0;
            default:   hd_in = req_payload.head[HW-1:0];
         endcase
      end else if (cmd.next_head) begin
         hd_in = hd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      hd_ff <= hd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_temp_ff <= 8'd90;
         min_samp_ff <= 8'd3;
         tol_ff      <= 8'd2;
         band_ff     <= 8'd3;
      end else if (csr_valid) begin
         if (csr_index == CSR_BOIL_MIN_TEMP) begin
            min_temp_ff <= csr_data;
         end
         if (csr_index == CSR_BOIL_MIN_SAMPLES) begin
            min_samp_ff <= csr_data;
         end
         if (csr_index == CSR_BOIL_TOLERANCE) begin
            tol_ff <= csr_data;
         end
         if (csr_index == CSR_HOLD_BAND) begin
            band_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HEADS; i++) begin
            run_ff[i]   <= RUN_OFF;
            menu_ff[i]  <= '0;
            pos_ff[i]   <= '0;
            cd_ff[i]    <= '0;
            htemp_ff[i] <= RESET_TEMP;
            lvl_ff[i]   <= '0;
            bcnt_ff[i]  <= '0;
            bsum_ff[i]  <= '0;
         end
         sel_ff <= '0;
      end else if (cmd.apply) begin
         run_ff[hd_ff]   <= n_run;
         menu_ff[hd_ff]  <= n_menu;
         pos_ff[hd_ff]   <= n_pos;
         cd_ff[hd_ff]    <= n_cd;
         htemp_ff[hd_ff] <= n_temp;
         lvl_ff[hd_ff]   <= n_lvl;
         bcnt_ff[hd_ff]  <= n_bcnt;
         bsum_ff[hd_ff]  <= n_bsum;
         sel_ff          <= n_sel;
      end
   end

   assign out_xfer = out_v_ff && !rsp_stall;

   always_comb begin
      out_nx             = pend_ff;
      out_nx.last_result = cmd.flush;
   end

   // One result waits in the pending stage until it is known whether it is the last.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         rescnt_ff <= '0;
         slotn_ff  <= '0;
         sloti_ff  <= '0;
      end else begin
         if (cmd.latch) begin
            rescnt_ff <= '0;
         end
         if (cmd.apply) begin
            slot0_ff <= n_slot0;
            slot1_ff <= n_slot1;
            slotn_ff <= n_slotn;
            sloti_ff <= '0;
         end
         if (cmd.drop) begin
            sloti_ff <= sloti_ff + 2'd1;
         end
         if (cmd.push) begin
            pend_ff   <= (sloti_ff == 2'd0) ? slot0_ff : slot1_ff;
            pend_v_ff <= 1'b1;
            sloti_ff  <= sloti_ff + 2'd1;
            rescnt_ff <= rescnt_ff + 4'd1;
         end
         if ((cmd.push && pend_v_ff) || cmd.flush) begin
            out_ff   <= out_nx;
            out_v_ff <= 1'b1;
         end else if (out_xfer) begin
            out_v_ff <= 1'b0;
         end
         if (cmd.flush) begin
            pend_v_ff <= 1'b0;
         end
      end
   end

   assign status.tick_op     = (op_ff == FUNC_TICK);
   assign status.tick_active = (c_run == RUN_ACTIVE) && (c_menu != 2'd0) &&
                               ({6'b0, c_menu} < MENUS_B) && (c_pos < menu_len(c_menu));
   assign status.last_head   = (hd_ff == HW'(HEADS - 1));
   assign status.div_busy    = div_busy;
   assign status.slot_have   = (sloti_ff < slotn_ff);
   assign status.res_full    = (rescnt_ff == MAX_RESULTS);
   assign status.pend_valid  = pend_v_ff;
   assign status.out_free    = !out_v_ff || !rsp_stall;

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;
endmodule

// ===== src/mhcs_ctrl.sv =====
// ---------------------------------------------------------------------------
// Cooking sequencer controller
// Sequences decode, the per-head tick walk, result emission and flush.
// ---------------------------------------------------------------------------
module mhcs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mhcs_pkg::mhcs_status_type status,
   output mhcs_pkg::mhcs_cmd_type    cmd
);
   import mhcs_pkg::*;

   mhcs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_START;
            end
         end
         ST_START: begin
            if (status.tick_op) begin
               state_in = ST_TICK_CHECK;
            end else begin
               cmd.apply = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_TICK_CHECK: begin
            if (status.tick_active) begin
               cmd.eval = 1'b1;
               state_in = ST_WAIT_DIV;
            end else if (status.last_head) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.next_head = 1'b1;
            end
         end
         ST_WAIT_DIV: begin
            if (!status.div_busy) begin
               cmd.apply = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.slot_have) begin
               if (status.res_full) begin
                  cmd.drop = 1'b1;
               end else if (!status.pend_valid || status.out_free) begin
                  cmd.push = 1'b1;
               end
            end else if (status.tick_op && !status.last_head) begin
               cmd.next_head = 1'b1;
               state_in      = ST_TICK_CHECK;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// ===== src/multi_head_cooking_sequencer.sv =====
// ---------------------------------------------------------------------------
// Multi-head cooking sequencer
// Recipe sequencer for several cooker heads with power and display results.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    mhcs_req_type
//   rsp      out        rsp_valid/stall    mhcs_rsp_type
//   csr      in         csr_valid/ready    csr_index, csr_data
//
// A key, report or command item is applied to its head and then emits its results one by one.
// A tick walks every head in turn: an idle head is passed over, an active head is evaluated,
// applied and emits its results, and waits while the serial divider forms the boil average.
// Reset is synchronous and restores all head state at once.
// Output stalls hold the walk only when a pending result must move into a
// stalled output register.
// ---------------------------------------------------------------------------
module multi_head_cooking_sequencer #(
   parameter int HEADS = 4,
   parameter int MENUS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mhcs_pkg::mhcs_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mhcs_pkg::mhcs_rsp_type rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_index,
   input  logic [7:0]             csr_data
);
   import mhcs_pkg::*;

   mhcs_cmd_type    cmd;
   mhcs_status_type status;

   assign csr_ready = 1'b1;

   mhcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mhcs_datapath #(
      .HEADS (HEADS),
      .MENUS (MENUS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && status.pend_valid) |-> status.out_free)
      else $error("pending result moved into a stalled output register");

   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !status.res_full)
      else $error("more results than the per-item limit");

   a_clean_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |-> (!status.pend_valid && !status.div_busy))
      else $error("new item accepted with previous work outstanding");
`endif
endmodule

// ===== sim/tb_multi_head_cooking_sequencer.sv =====
// ---------------------------------------------------------------------------
// Cooking sequencer testbench
// Drives key, report, command and tick items with bursty input and random
// output stalls. A behavioral model of the heads predicts every power and
// display result, and each result transfer is checked against it in order.
// ---------------------------------------------------------------------------
module tb_multi_head_cooking_sequencer;
   import mhcs_pkg::*;

   localparam int NHEADS   = 4;
   localparam int WDOG_MAX = 20000;
   localparam int REQ_W    = $bits(mhcs_req_type);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   mhcs_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   mhcs_rsp_type rsp_payload;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [7:0]   csr_data = '0;

   multi_head_cooking_sequencer dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted head state and settings.
   logic [7:0]  min_temp, min_samples, tolerance, band;
   logic [1:0]  run_st [NHEADS];
   logic [1:0]  menu [NHEADS];
   logic [1:0]  pos [NHEADS];
   logic [15:0] countdown [NHEADS];
   logic [7:0]  temp [NHEADS];
   logic [3:0]  level [NHEADS];
   logic [7:0]  bcount [NHEADS];
   logic [15:0] bsum [NHEADS];
   logic [1:0]  sel;

   mhcs_rsp_type expected_results[$];
   mhcs_rsp_type pending[$];
   int           errors = 0;
   int           idle_cycles = 0;
   bit           timed_out = 0;

   function automatic logic [10:0] watts(input logic [3:0] lv);
      case (lv)
         4'd1: return 11'd200;   4'd2: return 11'd300;   4'd3: return 11'd400;
         4'd4: return 11'd500;   4'd5: return 11'd1000;  4'd6: return 11'd1100;
         4'd7: return 11'd1200;  4'd8: return 11'd1300;  4'd9: return 11'd1500;
         4'd10: return 11'd2000;
         default: return 11'd0;
      endcase
   endfunction

   function automatic void push_res(input logic kind, input logic [1:0] h, input logic on,
                                    input logic [10:0] w, input logic [3:0] lv,
                                    input logic md, input logic [7:0] tgt,
                                    input logic [1:0] disp);
      mhcs_rsp_type r;
      r = '0;
      if (pending.size() >= 8) return;
      r.result_kind = kind; r.out_head = h; r.power_on = on; r.power_watts = w;
      r.power_level_out = lv; r.hold_mode = md; r.target_temp_out = tgt;
      r.display_code = disp;
      pending.push_back(r);
   endfunction

   function automatic bit boil_detect(input int h);
      int t, avg, d, s;
      t = temp[h];
      if (t < min_temp) begin
         bcount[h] = 0; bsum[h] = 0;
         return 0;
      end
      if (bcount[h] < 255) bcount[h]++;
      s = bsum[h] + t;
      bsum[h] = (s > 65535) ? 16'hFFFF : s[15:0];
      if (bcount[h] >= min_samples) begin
         avg = bsum[h] / bcount[h];
         d = (t >= avg) ? t - avg : avg - t;
         if (d < tolerance) begin
            bcount[h] = 0; bsum[h] = 0;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic void head_command(input int h, input logic [2:0] c,
                                        input logic [7:0] arg);
      if (h >= NHEADS) return;
      case (c)
         CMD_START: begin
            if (arg == 0 || arg >= TABLE_MENUS) return;
            menu[h] = arg[1:0]; pos[h] = 0;
            countdown[h] = 16'd0;
            bcount[h] = 0; bsum[h] = 0;
            run_st[h] = RUN_ACTIVE;
            push_res(KIND_DISPLAY, 2'(h), 0, 0, 0, 0, 0, DISP_STARTED);
         end
         CMD_STOP: begin
            run_st[h] = RUN_OFF; menu[h] = 0;
            push_res(KIND_POWER, 2'(h), 0, 0, 0, 0, 0, 0);
            push_res(KIND_DISPLAY, 2'(h), 0, 0, 0, 0, 0, DISP_STOPPED);
         end
         CMD_PAUSE: if (run_st[h] == RUN_ACTIVE) begin
            run_st[h] = RUN_PAUSED;
            push_res(KIND_POWER, 2'(h), 0, 0, 0, 0, 0, 0);
         end
         CMD_RESUME: if (run_st[h] == RUN_PAUSED) run_st[h] = RUN_ACTIVE;
         CMD_LEVEL: if (arg <= MAX_LEVEL) level[h] = arg[3:0];
         default: ;
      endcase
   endfunction

   // Menu table: 1 hold 65 at level 3, 2 fixed level 5,
   // 3 boil at level 10 then fixed level 2 for 1800 s.
   function automatic void second_tick();
      int mark, len, t;
      bit nxt;
      logic [3:0] lv;
      logic [10:0] p;
      for (int h = 0; h < NHEADS; h++) begin
         if (run_st[h] != RUN_ACTIVE || menu[h] == 0) continue;
         len = (menu[h] == 3) ? 2 : 1;
         if (pos[h] >= len) continue;
         if (countdown[h] > 0) countdown[h]--;
         mark = pending.size();
         nxt = 0;
         if (menu[h] == 1) begin
            lv = level[h] ? level[h] : 4'd3;
            t = temp[h];
            if (t + band < 65) p = watts(lv);
            else if (t > 65) p = 0;
            else p = (lv > 2) ? watts(lv - 4'd2) : 11'd200;
            push_res(KIND_POWER, 2'(h), p != 0, p, lv, 1, 8'd65, 0);
         end else if (menu[h] == 2) begin
            lv = level[h] ? level[h] : 4'd5;
            push_res(KIND_POWER, 2'(h), 1, watts(lv), lv, 0, 0, 0);
         end else if (pos[h] == 0) begin
            push_res(KIND_POWER, 2'(h), 1, 11'd2000, 4'd10, 0, 0, 0);
            nxt = boil_detect(h);
         end else begin
            lv = level[h] ? level[h] : 4'd2;
            push_res(KIND_POWER, 2'(h), 1, watts(lv), lv, 0, 0, 0);
            nxt = countdown[h] == 0;
         end
         if (nxt) begin
            pos[h]++;
            if (pos[h] >= len) begin
               while (pending.size() > mark) void'(pending.pop_back());
               run_st[h] = RUN_DONE;
               push_res(KIND_POWER, 2'(h), 0, 0, 0, 0, 0, 0);
               push_res(KIND_DISPLAY, 2'(h), 0, 0, 0, 0, 0, DISP_COMPLETE);
            end else begin
               countdown[h] = 16'd1800;
               bcount[h] = 0; bsum[h] = 0;
            end
         end
      end
   endfunction

   function automatic void predict_item(input mhcs_req_type q);
      pending.delete();
      case (q.func)
         FUNC_KEY: if (q.key_pressed) begin
            if (q.key_id == KEY_NEXT) sel = sel + 2'd1;
            else if (q.key_id == KEY_STOP) head_command(sel, CMD_STOP, 0);
            else if (q.key_id == KEY_WARM) head_command(sel, CMD_START, WARM_MENU);
            else if (q.key_id >= KEY_LEVEL_LO && q.key_id <= KEY_LEVEL_HI)
               head_command(sel, CMD_LEVEL, q.key_id - KEY_LEVEL_LO);
         end
         FUNC_TEMP: if (q.head < NHEADS) temp[q.head] = q.temperature;
         FUNC_TICK: second_tick();
         default: head_command(q.head, q.command, q.argument);
      endcase
      if (pending.size() > 0) pending[pending.size() - 1].last_result = 1'b1;
      foreach (pending[i]) expected_results.push_back(pending[i]);
   endfunction

   task automatic send_item(input mhcs_req_type q);
      int gap;
      // Bursts: most items follow back to back, some after a random gap.
      if ($urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(q);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BOIL_MIN_TEMP:    min_temp = val;
         CSR_BOIL_MIN_SAMPLES: min_samples = val;
         CSR_BOIL_TOLERANCE:   tolerance = val;
         default:              band = val;
      endcase
   endtask

   function automatic mhcs_req_type make(input logic [1:0] f, input logic [7:0] kc,
                                         input logic [7:0] h, input logic [2:0] c,
                                         input logic [7:0] arg, input logic [7:0] t);
      mhcs_req_type q;
      q.func = f; q.key_id = kc; q.key_pressed = 1'b1; q.head = h;
      q.command = c; q.argument = arg; q.temperature = t;
      return q;
   endfunction

   task automatic test_directed();
      send_item(make(FUNC_CMD, 0, 0, CMD_START, 1, 0));
      send_item(make(FUNC_CMD, 0, 1, CMD_START, 2, 0));
      send_item(make(FUNC_CMD, 0, 2, CMD_START, 3, 0));
      send_item(make(FUNC_CMD, 0, 3, CMD_START, 0, 0));
      send_item(make(FUNC_CMD, 0, 3, CMD_START, 8'hFF, 0));
      send_item(make(FUNC_TICK, 0, 0, 0, 0, 0));
      send_item(make(FUNC_TEMP, 0, 0, 0, 0, 8'd255));
      send_item(make(FUNC_TEMP, 0, 2, 0, 0, 8'd100));
      send_item(make(FUNC_TEMP, 0, 8'hFF, 0, 0, 8'd7));
      send_item(make(FUNC_CMD, 0, 1, CMD_LEVEL, 10, 0));
      send_item(make(FUNC_CMD, 0, 1, CMD_LEVEL, 11, 0));
      repeat (4) send_item(make(FUNC_TICK, 0, 0, 0, 0, 0));
      send_item(make(FUNC_CMD, 0, 1, CMD_PAUSE, 0, 0));
      send_item(make(FUNC_CMD, 0, 1, CMD_PAUSE, 0, 0));
      send_item(make(FUNC_CMD, 0, 1, CMD_RESUME, 0, 0));
      send_item(make(FUNC_CMD, 0, 1, CMD_RESUME, 0, 0));
      send_item(make(FUNC_CMD, 0, 0, 3'd7, 0, 0));
      send_item(make(FUNC_KEY, KEY_WARM, 0, 0, 0, 0));
      send_item(make(FUNC_KEY, KEY_LEVEL_HI, 0, 0, 0, 0));
      send_item(make(FUNC_KEY, KEY_NEXT, 0, 0, 0, 0));
      send_item(make(FUNC_KEY, KEY_STOP, 0, 0, 0, 0));
      send_item(make(FUNC_KEY, 8'hFF, 0, 0, 0, 0));
      send_item(make(FUNC_CMD, 0, 2, CMD_STOP, 0, 0));
      drain();
   endtask

   function automatic mhcs_req_type random_item();
      mhcs_req_type q;
      int r;
      q = mhcs_req_type'(REQ_W'({$urandom, $urandom}));
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) != 0) q.head[7:2] = 0;
      if (r < 35) q.func = FUNC_TICK;
      else if (r < 60) begin
         q.func = FUNC_TEMP;
         if ($urandom_range(0, 1)) q.temperature = 8'($urandom_range(85, 110));
      end else if (r < 85) begin
         q.func = FUNC_CMD;
         if ($urandom_range(0, 3) != 0) q.command = 3'($urandom_range(1, 5));
         if ($urandom_range(0, 2) != 0) q.argument = 8'($urandom_range(0, 11));
      end else begin
         q.func = FUNC_KEY;
         case ($urandom_range(0, 4))
            0: q.key_id = KEY_NEXT;
            1: q.key_id = KEY_STOP;
            2: q.key_id = KEY_WARM;
            3: q.key_id = 8'($urandom_range(KEY_LEVEL_LO, 8'h1A));
            default: ;
         endcase
      end
      return q;
   endfunction

   task automatic test_random(input int n);
      repeat (n) send_item(random_item());
      drain();
   endtask

   task automatic test_config(input logic [7:0] mt, input logic [7:0] ms,
                              input logic [7:0] tol, input logic [7:0] hb);
      write_csr(CSR_BOIL_MIN_TEMP, mt);
      write_csr(CSR_BOIL_MIN_SAMPLES, ms);
      write_csr(CSR_BOIL_TOLERANCE, tol);
      write_csr(CSR_HOLD_BAND, hb);
      csr_valid <= 1'b0;
   endtask

   // Result checker and output stall pattern.
   always @(posedge clock) begin
      mhcs_rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_payload);
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (e !== rsp_payload) begin
                  $display("%0t: result mismatch expected %p actual %p", $time, e, rsp_payload);
                  errors++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         rsp_stall <= ($time / 400) % 3 == 0 ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WDOG_MAX && !timed_out) begin
         timed_out = 1;
         $display("tb_multi_head_cooking_sequencer: done, errors");
         $finish;
      end
   end

   initial begin
      min_temp = 90; min_samples = 3; tolerance = 2; band = 3; sel = 0;
      for (int h = 0; h < NHEADS; h++) begin
         run_st[h] = 0; menu[h] = 0; pos[h] = 0; countdown[h] = 0;
         temp[h] = RESET_TEMP; level[h] = 0; bcount[h] = 0; bsum[h] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(140);
      test_config(8'd0, 8'd1, 8'd255, 8'd0);
      test_random(100);
      test_config(8'd255, 8'd255, 8'd0, 8'd255);
      test_random(60);
      test_config(8'd95, 8'd2, 8'd4, 8'd10);
      test_random(100);
      if (errors == 0)
         $display("tb_multi_head_cooking_sequencer: done, clean");
      else
         $display("tb_multi_head_cooking_sequencer: done, errors");
      $finish;
   end

endmodule

// ===== multi_head_cooking_sequencer.f =====
src/mhcs_pkg.sv
src/mhcs_div.sv
src/mhcs_datapath.sv
src/mhcs_ctrl.sv
src/multi_head_cooking_sequencer.sv
sim/tb_multi_head_cooking_sequencer.sv
